/* sv/feature_accumulator_update_core_macros.svh */
// assertion macros for the feature accumulator core
`ifndef FEATURE_ACCUMULATOR_UPDATE_CORE_MACROS_SVH
`define FEATURE_ACCUMULATOR_UPDATE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define FAU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fau assertion failed");
`define FAU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fau assertion failed");
`else
`define FAU_ASSERT_IMP(lbl, ante, cons)
`define FAU_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* sv/fau_pkg.sv */
package fau_pkg;

  typedef logic [2:0]        kind_t;
  typedef logic [9:0]        feat_t;
  typedef logic [7:0]        lane_t;
  typedef logic signed [15:0] word_t;

  localparam kind_t KIND_WR_WEIGHT = 3'd0;
  localparam kind_t KIND_WR_BIAS   = 3'd1;
  localparam kind_t KIND_REFRESH   = 3'd2;
  localparam kind_t KIND_ADD       = 3'd3;
  localparam kind_t KIND_REMOVE    = 3'd4;
  localparam kind_t KIND_READ      = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STREAM,
    ST_DRAIN,
    ST_RD,
    ST_RDW
  } state_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic rd_issue;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic last_beat;
    logic wr_pending;
    logic out_free;
  } status_t;

endpackage

/* sv/fau_if.sv */
interface fau_in_if;
  import fau_pkg::*;
  logic  valid;
  logic  ready;
  kind_t kind;
  logic  perspective;
  feat_t feature;
  lane_t lane;
  word_t value;

  modport source (output valid, kind, perspective, feature, lane, value, input ready);
  modport sink   (input valid, kind, perspective, feature, lane, value, output ready);
endinterface

interface fau_out_if;
  import fau_pkg::*;
  logic  valid;
  logic  ready;
  word_t lane_value;
  lane_t lane_index;

  modport source (output valid, lane_value, lane_index, input ready);
  modport sink   (input valid, lane_value, lane_index, output ready);
endinterface

/* sv/fau_ctrl.sv */
module fau_ctrl #(
  parameter int FEATURES = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  fau_pkg::kind_t  in_kind,
  input  fau_pkg::feat_t  in_feature,
  input  fau_pkg::status_t status,
  output logic            in_ready,
  output fau_pkg::cmd_t   cmd
);
  import fau_pkg::*;

  state_t state_r, state_nxt;
  logic   feat_ok;

  assign feat_ok = 32'(in_feature) < FEATURES;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (in_kind)
            KIND_REFRESH: state_nxt = ST_STREAM;
            KIND_ADD, KIND_REMOVE: begin
              // out-of-range feature is a no-op
              if (feat_ok) state_nxt = ST_STREAM;
            end
            KIND_READ: state_nxt = ST_RD;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_STREAM: begin
        cmd.issue = 1'b1;
        if (status.last_beat) state_nxt = ST_DRAIN;
      end
      // last row write lands here
      ST_DRAIN: state_nxt = ST_IDLE;
      ST_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_RDW;
      end
      ST_RDW: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* sv/fau_dp.sv */
module fau_dp #(
  parameter int LANES           = 256,
  parameter int FEATURES        = 1024,
  parameter int LANES_PER_CYCLE = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  fau_pkg::cmd_t    cmd,
  input  fau_pkg::kind_t   in_kind,
  input  logic             in_perspective,
  input  fau_pkg::feat_t   in_feature,
  input  fau_pkg::lane_t   in_lane,
  input  fau_pkg::word_t   in_value,
  output fau_pkg::status_t status,
  output logic             out_valid,
  input  logic             out_ready,
  output fau_pkg::word_t   out_lane_value,
  output fau_pkg::lane_t   out_lane_index
);
  import fau_pkg::*;

  localparam int BEATS  = (LANES + LANES_PER_CYCLE - 1) / LANES_PER_CYCLE;
  localparam int BW     = (BEATS > 1) ? $clog2(BEATS) : 1;
  localparam int SW     = (LANES_PER_CYCLE > 1) ? $clog2(LANES_PER_CYCLE) : 1;
  localparam int AAW    = $clog2(2 * BEATS);
  localparam int WDEPTH = FEATURES * BEATS;
  localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

  typedef logic [LANES_PER_CYCLE-1:0][15:0] row_t;

  // lane -> (beat, slot) split, constant tables
  logic [BW-1:0] beat_tab [256];
  logic [SW-1:0] slot_tab [256];

  for (genvar g = 0; g < 256; g++) begin : g_tab
    assign beat_tab[g] = BW'(g / LANES_PER_CYCLE);
    assign slot_tab[g] = SW'(g % LANES_PER_CYCLE);
  end

  // latched item
  kind_t         kind_r;
  logic          side_r;
  feat_t         feat_r;
  lane_t         lane_r;
  logic [BW-1:0] beat_r, beat_nxt;

  // row write stage
  logic          wr_vld_r;
  logic [BW-1:0] wr_beat_r;

  // memories and their registered read data
  row_t wmem [WDEPTH];
  row_t bmem [BEATS];
  row_t amem [2*BEATS];
  row_t w_rd_r, b_rd_r, a_rd_r;

  logic           out_valid_r;
  logic [15:0]    lane_value_r;
  lane_t          lane_index_r;

  logic           lane_ok_in, lane_ok_r, is_update;
  logic           w_we, b_we, w_re, b_re, a_re;
  logic [31:0]    w_full, a_rd_full, a_wr_full;
  logic [WAW-1:0] w_addr;
  logic [BW-1:0]  b_addr;
  logic [SW-1:0]  w_sel;
  logic [AAW-1:0] a_rd_addr, a_wr_addr;
  row_t           a_wdata;

  assign lane_ok_in = 32'(in_lane) < LANES;
  assign lane_ok_r  = 32'(lane_r) < LANES;
  assign is_update  = (kind_r == KIND_ADD) || (kind_r == KIND_REMOVE);

  assign w_we = cmd.accept && (in_kind == KIND_WR_WEIGHT) && lane_ok_in
                && (32'(in_feature) < FEATURES);
  assign b_we = cmd.accept && (in_kind == KIND_WR_BIAS) && lane_ok_in;
  assign w_re = cmd.issue && is_update;
  assign b_re = cmd.issue && (kind_r == KIND_REFRESH);
  assign a_re = (cmd.issue && is_update) || cmd.rd_issue;

  assign w_full = cmd.accept ?
                  32'(in_feature) * 32'(BEATS) + 32'(beat_tab[in_lane]) :
                  32'(feat_r) * 32'(BEATS) + 32'(beat_r);
  assign w_addr = w_full[WAW-1:0];
  assign w_sel  = slot_tab[in_lane];
  assign b_addr = cmd.accept ? beat_tab[in_lane] : beat_r;

  assign a_rd_full = 32'(side_r) * 32'(BEATS) +
                     32'(cmd.rd_issue ? beat_tab[lane_r] : beat_r);
  assign a_rd_addr = a_rd_full[AAW-1:0];
  assign a_wr_full = 32'(side_r) * 32'(BEATS) + 32'(wr_beat_r);
  assign a_wr_addr = a_wr_full[AAW-1:0];

  always_comb begin
    for (int i = 0; i < LANES_PER_CYCLE; i++) begin
      case (kind_r)
        KIND_ADD:    a_wdata[i] = a_rd_r[i] + w_rd_r[i];
        KIND_REMOVE: a_wdata[i] = a_rd_r[i] - w_rd_r[i];
        default:     a_wdata[i] = b_rd_r[i];
      endcase
    end
  end

  always_comb begin
    beat_nxt = beat_r;
    if (cmd.accept) begin
      beat_nxt = '0;
    end else if (cmd.issue) begin
      beat_nxt = beat_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r      <= '0;
      wr_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      beat_r   <= beat_nxt;
      wr_vld_r <= cmd.issue;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= in_kind;
      side_r <= in_perspective;
      feat_r <= in_feature;
      lane_r <= in_lane;
    end
    wr_beat_r <= beat_r;
    if (cmd.load_out) begin
      lane_value_r <= lane_ok_r ? a_rd_r[slot_tab[lane_r]] : 16'h0000;
      lane_index_r <= lane_r;
    end
  end

  // weight memory: one word written, one row read
  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES_PER_CYCLE; i++) begin
      if (w_we && (w_sel == SW'(i))) wmem[w_addr][i] <= in_value;
    end
    if (w_re) w_rd_r <= wmem[w_addr];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES_PER_CYCLE; i++) begin
      if (b_we && (w_sel == SW'(i))) bmem[b_addr][i] <= in_value;
    end
    if (b_re) b_rd_r <= bmem[b_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_vld_r) amem[a_wr_addr] <= a_wdata;
    if (a_re) a_rd_r <= amem[a_rd_addr];
  end

  assign status.last_beat  = 32'(beat_r) == BEATS - 1;
  assign status.wr_pending = wr_vld_r;
  assign status.out_free   = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_lane_value = lane_value_r;
  assign out_lane_index = lane_index_r;

endmodule

/* sv/feature_accumulator_update_core.sv */
// weight and bias word writes are taken directly from idle; kinds 6 and 7 are accepted and ignored
// refresh, add and remove stream ceil(LANES/LANES_PER_CYCLE) rows (16 by default),
// one row of LANES_PER_CYCLE lanes per cycle from weight memory, or bias on refresh
// a lane read fetches its row, then shows its result once out is free (not stalled)
// synchronous active-low reset clears control state only; weight, bias and
// accumulator memories hold undefined data until written or refreshed
`include "feature_accumulator_update_core_macros.svh"

module feature_accumulator_update_core #(
  parameter int LANES           = 256,
  parameter int FEATURES        = 1024,
  parameter int LANES_PER_CYCLE = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  fau_in_if.sink    in_if,
  fau_out_if.source out_if
);
  import fau_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in_if.ready = in_ready;

  fau_ctrl #(
    .FEATURES (FEATURES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_kind    (in_if.kind),
    .in_feature (in_if.feature),
    .status     (status),
    .in_ready   (in_ready),
    .cmd        (cmd)
  );

  fau_dp #(
    .LANES           (LANES),
    .FEATURES        (FEATURES),
    .LANES_PER_CYCLE (LANES_PER_CYCLE)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_kind        (in_if.kind),
    .in_perspective (in_if.perspective),
    .in_feature     (in_if.feature),
    .in_lane        (in_if.lane),
    .in_value       (in_if.value),
    .status         (status),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_lane_value (out_if.lane_value),
    .out_lane_index (out_if.lane_index)
  );

  // every issued row read is followed by its row write
  `FAU_ASSERT_NXT(a_issue_then_write, cmd.issue, status.wr_pending)
  // no item taken while a row write is still in flight
  `FAU_ASSERT_IMP(a_idle_no_write, in_if.ready, !status.wr_pending)
  // a result only appears after a lane read loaded it
  `FAU_ASSERT_IMP(a_result_from_load, $rose(out_if.valid), $past(cmd.load_out))
  `FAU_ASSERT_NXT(a_read_holds_input, cmd.rd_issue, !in_if.ready)

endmodule

/* verif/feature_accumulator_update_core_test.sv */
module feature_accumulator_update_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fau_pkg::*;

  localparam int LANE_COUNT    = 256;
  localparam int FEATURE_COUNT = 1024;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_RELOADS   = 3;

  // kinds the block must ignore
  localparam kind_t KIND_SPARE_A = 3'd6;
  localparam kind_t KIND_SPARE_B = 3'd7;

  localparam word_t WORD_MAX = 16'sh7FFF;
  localparam word_t WORD_MIN = 16'sh8000;

  typedef struct {
    kind_t kind;
    logic  side;
    feat_t feature;
    lane_t lane;
    word_t value;
  } acc_cmd_t;

  typedef struct {
    word_t lane_value;
    lane_t lane_index;
  } lane_read_t;

  logic clk;
  logic rst_n;

  fau_in_if  in_bus();
  fau_out_if out_bus();

  feature_accumulator_update_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_bus),
    .out_if(out_bus)
  );

  acc_cmd_t   cmd_backlog[$];
  lane_read_t lane_reads_due[$];

  // shadow copy of the block's stores, updated as items are accepted
  word_t weight_mem [bit [17:0]];
  word_t bias_mem [LANE_COUNT];
  word_t acc_mem [2][LANE_COUNT];

  // what the stimulus has written so far, so it never touches undefined data
  bit [LANE_COUNT-1:0] row_written [FEATURE_COUNT];
  bit                  row_full [FEATURE_COUNT];
  bit [LANE_COUNT-1:0] bias_written;
  bit                  side_refreshed [2];
  int                  full_rows[$];
  int                  counted_items;

  int errors;
  int accepted;
  int reads_checked;
  int row_updates;
  int refreshes;
  int idle_cycles;

  acc_cmd_t   on_bus;
  int         burst_left;
  int         gap_left;
  lane_read_t due;
  int         stall_mode;
  int         stall_tick;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void track_accumulators(acc_cmd_t c);
    lane_read_t r;
    case (c.kind)
      KIND_WR_WEIGHT: weight_mem[{c.feature, c.lane}] = c.value;
      KIND_WR_BIAS:   bias_mem[c.lane] = c.value;
      KIND_REFRESH: begin
        for (int i = 0; i < LANE_COUNT; i++) acc_mem[c.side][i] = bias_mem[i];
        refreshes++;
      end
      KIND_ADD, KIND_REMOVE: begin
        for (int i = 0; i < LANE_COUNT; i++) begin
          if (c.kind == KIND_ADD)
            acc_mem[c.side][i] = acc_mem[c.side][i] + weight_mem[{c.feature, lane_t'(i)}];
          else
            acc_mem[c.side][i] = acc_mem[c.side][i] - weight_mem[{c.feature, lane_t'(i)}];
        end
        row_updates++;
      end
      KIND_READ: begin
        r.lane_value = acc_mem[c.side][c.lane];
        r.lane_index = c.lane;
        lane_reads_due.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic void push_cmd(kind_t k, logic s, feat_t f, lane_t l, word_t v);
    acc_cmd_t c;
    c = '{k, s, f, l, v};
    case (k)
      KIND_WR_WEIGHT: begin
        row_written[f][l] = 1'b1;
        if (&row_written[f] && !row_full[f]) begin
          row_full[f] = 1'b1;
          full_rows.push_back(int'(f));
        end
      end
      KIND_WR_BIAS: bias_written[l] = 1'b1;
      KIND_REFRESH: side_refreshed[s] = 1'b1;
      default: ;
    endcase
    if (k <= KIND_READ) counted_items++;
    cmd_backlog.push_back(c);
  endfunction

  function automatic word_t random_word();
    case ($urandom_range(0, 7))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      3: return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  // alternating extremes: even lanes max, odd lanes min
  function automatic void load_row(feat_t f, bit extremes);
    int   start;
    lane_t l;
    start = $urandom_range(0, LANE_COUNT - 1);
    for (int i = 0; i < LANE_COUNT; i++) begin
      l = lane_t'(i + start);
      push_cmd(KIND_WR_WEIGHT, 1'($urandom), f, l,
               extremes ? (l[0] ? WORD_MIN : WORD_MAX) : random_word());
    end
  endfunction

  function automatic void load_bias();
    for (int i = 0; i < LANE_COUNT; i++) begin
      push_cmd(KIND_WR_BIAS, 1'($urandom), feat_t'($urandom), lane_t'(i),
               (i == 0) ? WORD_MAX : (i == LANE_COUNT - 1) ? WORD_MIN : random_word());
    end
  endfunction

  function automatic feat_t any_full_row();
    return feat_t'(full_rows[$urandom_range(0, full_rows.size() - 1)]);
  endfunction

  function automatic void push_update(logic s);
    push_cmd(($urandom_range(0, 2) == 0) ? KIND_REMOVE : KIND_ADD, s, any_full_row(),
             lane_t'($urandom), random_word());
  endfunction

  task automatic wait_quiet();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || in_bus.valid || lane_reads_due.size() != 0);
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        track_accumulators(on_bus);
        accepted++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left > 0 || cmd_backlog.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_bus.valid <= 1'b0;
        end else begin
          on_bus = cmd_backlog.pop_front();
          in_bus.valid       <= 1'b1;
          in_bus.kind        <= on_bus.kind;
          in_bus.perspective <= on_bus.side;
          in_bus.feature     <= on_bus.feature;
          in_bus.lane        <= on_bus.lane;
          in_bus.value       <= on_bus.value;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                    : $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // receiver: checks lane reads, stalls in changing patterns
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_mode = 0;
      stall_tick = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (lane_reads_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected lane read result: expected none, actual value %0d lane %0d",
                   $time, out_bus.lane_value, out_bus.lane_index);
        end else begin
          due = lane_reads_due.pop_front();
          reads_checked++;
          if (out_bus.lane_value !== due.lane_value) begin
            errors++;
            $display("%0t: lane_value mismatch: expected %0d, actual %0d", $time,
                     due.lane_value, out_bus.lane_value);
          end
          if (out_bus.lane_index !== due.lane_index) begin
            errors++;
            $display("%0t: lane_index mismatch: expected %0d, actual %0d", $time,
                     due.lane_index, out_bus.lane_index);
          end
        end
      end
      stall_tick++;
      if (stall_tick % 150 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_bus.ready <= 1'b1;
        1: out_bus.ready <= 1'($urandom);
        2: out_bus.ready <= (stall_tick % 4 == 0);
        default: out_bus.ready <= (stall_tick % 16 < 2);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int    pick;
    int    reloads;
    logic  s;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.kind = KIND_WR_WEIGHT;
    in_bus.perspective = 1'b0;
    in_bus.feature = '0;
    in_bus.lane = '0;
    in_bus.value = '0;
    out_bus.ready = 1'b0;
    errors = 0;
    idle_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // preload: full bias vector and three complete weight rows
    load_bias();
    load_row(10'd1023, 1'b1);
    load_row(10'd0, 1'b0);
    load_row(10'd341, 1'b0);
    wait_quiet();

    push_cmd(KIND_REFRESH, 1'b0, 10'd0, 8'd0, '0);
    push_cmd(KIND_REFRESH, 1'b1, 10'd1023, 8'd255, '1);
    push_cmd(KIND_READ, 1'b0, 10'd0, 8'd0, '0);
    push_cmd(KIND_READ, 1'b1, 10'd1023, 8'd255, WORD_MIN);
    // max plus max and min plus min both wrap
    push_cmd(KIND_ADD, 1'b0, 10'd1023, 8'd0, '0);
    push_cmd(KIND_REMOVE, 1'b1, 10'd0, 8'd0, '0);
    push_cmd(KIND_ADD, 1'b1, 10'd341, 8'd0, '0);
    push_cmd(KIND_READ, 1'b0, 10'd0, 8'd0, '0);
    push_cmd(KIND_READ, 1'b0, 10'd0, 8'd1, '0);
    push_cmd(KIND_READ, 1'b0, 10'd0, 8'd255, '0);
    push_cmd(KIND_READ, 1'b1, 10'd0, 8'd0, '0);
    push_cmd(KIND_READ, 1'b1, 10'd0, 8'd128, '0);
    push_cmd(KIND_SPARE_A, 1'b1, 10'd1023, 8'd255, '1);
    push_cmd(KIND_SPARE_B, 1'b0, 10'd0, 8'd0, '0);
    push_cmd(KIND_SPARE_B, 1'b1, 10'd1023, 8'd255, WORD_MIN);
    push_cmd(KIND_WR_WEIGHT, 1'b1, 10'd1023, 8'd0, WORD_MIN);
    push_cmd(KIND_WR_BIAS, 1'b0, 10'd1023, 8'd255, WORD_MAX);
    push_cmd(KIND_REMOVE, 1'b0, 10'd1023, 8'd255, '0);
    push_cmd(KIND_READ, 1'b0, 10'd0, 8'd0, '0);
    push_cmd(KIND_REFRESH, 1'b0, 10'd512, 8'd128, '0);
    push_cmd(KIND_READ, 1'b0, 10'd0, 8'd255, '0);
    push_cmd(KIND_ADD, 1'b0, 10'd0, 8'd0, '0);
    push_cmd(KIND_READ, 1'b0, 10'd0, 8'd17, '0);
    wait_quiet();

    reloads = 0;
    while (counted_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      s = 1'($urandom);
      if (pick < 2 && reloads < MAX_RELOADS) begin
        load_row(feat_t'($urandom), 1'b0);
        reloads++;
      end else if (pick == 2 && reloads < MAX_RELOADS) begin
        load_bias();
        reloads++;
      end else if (pick < 60) begin
        // refresh if needed or at random, a run of updates, maybe a bias write, then a few lane reads
        if (!side_refreshed[s] || $urandom_range(0, 2) == 0)
          push_cmd(KIND_REFRESH, s, feat_t'($urandom), lane_t'($urandom), random_word());
        repeat ($urandom_range(1, 6)) push_update(s);
        if ($urandom_range(0, 3) == 0)
          push_cmd(KIND_WR_BIAS, s, feat_t'($urandom), lane_t'($urandom), random_word());
        repeat ($urandom_range(1, 4))
          push_cmd(KIND_READ, s, feat_t'($urandom), lane_t'($urandom), random_word());
      end else if (pick < 78) begin
        if (!side_refreshed[s])
          push_cmd(KIND_REFRESH, s, feat_t'($urandom), lane_t'($urandom), random_word());
        else if ($urandom_range(0, 1) == 0)
          push_cmd(KIND_READ, s, feat_t'($urandom), lane_t'($urandom), random_word());
        else
          push_update(s);
      end else if (pick < 92) begin
        if ($urandom_range(0, 2) == 0)
          push_cmd(KIND_WR_BIAS, s, feat_t'($urandom), lane_t'($urandom), random_word());
        else
          push_cmd(KIND_WR_WEIGHT, s, feat_t'($urandom), lane_t'($urandom), random_word());
      end else if (pick < 98) begin
        push_cmd(($urandom_range(0, 1) == 0) ? KIND_SPARE_A : KIND_SPARE_B, s,
                 feat_t'($urandom), lane_t'($urandom), random_word());
      end else begin
        wait_quiet();
      end
    end

    wait_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (lane_reads_due.size() != 0) begin
      errors++;
      $display("%0t: lane reads outstanding: expected 0, actual %0d", $time,
               lane_reads_due.size());
    end
    $display("run covered %0d accepted items and %0d checked lane reads", accepted,
             reads_checked);
    $display("with %0d refreshes, %0d row updates and %0d complete weight rows", refreshes,
             row_updates, full_rows.size());
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
